/* sv/rdm_pkg.sv */
// Shared constants, codes and types for the dot-star regular-expression matcher.
// No dependencies; every other file of the block but rdm_result_if imports this package.
package rdm_pkg;

    // Largest pattern the block holds, in characters.
    localparam int PATTERN_MAX = 16;
    localparam int LEN_W       = 5;
    localparam int ROW_W       = PATTERN_MAX + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    typedef logic [7:0]            char_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [ROW_W-1:0]      row_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // Pattern characters with a special meaning.
    localparam char_t DOT_CHAR  = 8'h2E;
    localparam char_t STAR_CHAR = 8'h2A;

    // Item operation codes.
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_APPEND  = 1'b1;

    // Configuration register indexes.
    localparam cfg_idx_t REG_PATTERN_LOW  = 2'd0;
    localparam cfg_idx_t REG_PATTERN_HIGH = 2'd1;
    localparam cfg_idx_t REG_PATTERN_LEN  = 2'd2;

    // Controls broadcast from the top level to every cell.
    typedef struct packed {
        logic  advance;
        logic  restart;
        char_t text_byte;
    } cell_ctl_t;

endpackage

/* sv/rdm_item_if.sv */
// Input channel of the matcher: one operation and one text byte per request.
// Depends on rdm_pkg.
interface rdm_item_if;
    import rdm_pkg::*;

    logic  valid;
    logic  ready;
    logic  op;
    char_t text_byte;

    modport source (output valid, output op, output text_byte, input ready);
    modport sink   (input valid, input op, input text_byte, output ready);
endinterface

/* sv/rdm_result_if.sv */
// Result channel of the matcher: one match flag per request.
// No dependencies.
interface rdm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

/* sv/rdm_cfg_if.sv */
// Configuration write channel of the matcher: register index and write data.
// Depends on rdm_pkg.
interface rdm_cfg_if;
    import rdm_pkg::*;

    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/rdm_cell.sv */
// One cell of the match row: holds the bit for one pattern prefix length.
// Depends on rdm_pkg.
module rdm_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  rdm_pkg::cell_ctl_t ctl,
    input  logic              enable,
    input  rdm_pkg::char_t    pat_char,
    input  rdm_pkg::char_t    prev_char,
    input  logic              has_prev,
    input  logic              left_bit,
    input  logic              skip_bit,
    output logic              new_bit,
    output logic              row_bit
);
    import rdm_pkg::*;

    logic row_reg;
    logic row_next;
    logic is_star;
    logic prev_hit;
    logic self_hit;

    // Character comparisons against the incoming text byte.
    assign is_star  = (pat_char == STAR_CHAR);
    assign prev_hit = (ctl.text_byte == prev_char) || (prev_char == DOT_CHAR);
    assign self_hit = (ctl.text_byte == pat_char) || (pat_char == DOT_CHAR);

    // New value of this prefix bit; the skip bit comes from two cells back.
    always_comb
    begin
        new_bit = 1'b0;
        if (enable)
        begin
            if (ctl.restart)
            begin
                new_bit = is_star && has_prev && skip_bit;
            end
            else if (is_star)
            begin
                if (has_prev)
                begin
                    new_bit = prev_hit ? (left_bit | row_reg | skip_bit) : skip_bit;
                end
            end
            else
            begin
                new_bit = self_hit && left_bit;
            end
        end
    end

    assign row_next = ctl.advance ? new_bit : row_reg;

    // Row bit storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row_bit = row_reg;

endmodule

/* sv/regex_dot_star_matcher.sv */
// Streaming '.'/'*' regular-expression matcher built as a row of match cells.
// The result of a request is registered and presented in the cycle after it is accepted.
// Throughput: one request per cycle while the result is taken; the new row ripples through the cell chain.
// A new request is taken in the cycle the held result leaves; a stalled result holds the input.
// Reset clears the pattern, its length and the match row, so results are 0
// until the first restart. Depends on rdm_pkg, the interfaces and rdm_cell.
module regex_dot_star_matcher (
    input  logic     clk,
    input  logic     rst_n,
    rdm_item_if.sink     item,
    rdm_result_if.source result,
    rdm_cfg_if.sink      cfg
);
    import rdm_pkg::*;

    cfg_data_t pat_low_reg;
    cfg_data_t pat_low_next;
    cfg_data_t pat_high_reg;
    cfg_data_t pat_high_next;
    len_t      len_reg;
    len_t      len_next;
    len_t      len_used;
    logic      row0_reg;
    logic      row0_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      matched_reg;
    logic      matched_next;
    logic      acc;
    logic      cfg_wr;
    cell_ctl_t ctl;
    row_t      new_row;
    row_t      old_row;
    char_t     pat [PATTERN_MAX];

    // Handshakes; configuration is always taken.
    assign cfg.ready  = 1'b1;
    assign cfg_wr     = cfg.valid;
    assign item.ready = !out_valid_reg || result.ready;
    assign acc        = item.valid && item.ready;

    // Configuration register writes.
    always_comb
    begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        len_next      = len_reg;
        if (cfg_wr)
        begin
            case (cfg.index)
                REG_PATTERN_LOW:  pat_low_next  = cfg.data;
                REG_PATTERN_HIGH: pat_high_next = cfg.data;
                REG_PATTERN_LEN:  len_next      = cfg.data[LEN_W-1:0];
                default:          len_next      = len_reg;
            endcase
        end
    end

    // Length in use, clamped to the capacity of the cell row.
    assign len_used = (len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_reg;

    // Split the pattern registers into characters.
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (k < 8)
            begin
                pat[k] = pat_low_reg[8*k +: 8];
            end
            else
            begin
                pat[k] = pat_high_reg[8*(k-8) +: 8];
            end
        end
    end

    // Controls shared by all cells.
    assign ctl.advance   = acc;
    assign ctl.restart   = (item.op == OP_RESTART);
    assign ctl.text_byte = item.text_byte;

    // The empty-prefix bit: set by a restart, cleared by any text byte.
    assign new_row[0] = ctl.restart;
    assign old_row[0] = row0_reg;
    assign row0_next  = acc ? new_row[0] : row0_reg;

    // Row of cells, one per pattern prefix length.
    genvar j;
    generate
        for (j = 1; j <= PATTERN_MAX; j++)
        begin : g_cell
            logic  en;
            logic  skip;
            char_t prev;

            assign en = (LEN_W'(j) <= len_used);
            if (j >= 2)
            begin : g_prev
                assign skip = new_row[j-2];
                assign prev = pat[j-2];
            end
            else
            begin : g_first
                assign skip = 1'b0;
                assign prev = 8'h00;
            end

            rdm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .enable    (en),
                .pat_char  (pat[j-1]),
                .prev_char (prev),
                .has_prev  (j >= 2),
                .left_bit  (old_row[j-1]),
                .skip_bit  (skip),
                .new_bit   (new_row[j]),
                .row_bit   (old_row[j])
            );
        end
    endgenerate

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;
        if (acc)
        begin
            out_valid_next = 1'b1;
            matched_next   = new_row[len_used];
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.matched = matched_reg;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            len_reg       <= '0;
            row0_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            matched_reg   <= 1'b0;
        end
        else
        begin
            pat_low_reg   <= pat_low_next;
            pat_high_reg  <= pat_high_next;
            len_reg       <= len_next;
            row0_reg      <= row0_next;
            out_valid_reg <= out_valid_next;
            matched_reg   <= matched_next;
        end
    end

    // A restart always leaves the empty prefix matching.
    a_restart_row0: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (item.op == OP_RESTART) |=> row0_reg)
        else $error("empty-prefix bit not set after restart");

    // A text byte always clears the empty prefix.
    a_append_row0: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (item.op == OP_APPEND) |=> !row0_reg)
        else $error("empty-prefix bit not cleared by text byte");

    // An empty pattern matches the empty text right after a restart.
    a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (item.op == OP_RESTART) && (len_reg == '0) |=> matched_reg)
        else $error("empty pattern failed to match empty text");

    // A result appears only after a request has been accepted.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(acc))
        else $error("result raised without an accepted request");

endmodule
